// File: rtl/core/qrk_pkg.sv
// Package for the queue with reverse-first-k block.
// Holds the sizing constants, operation and status codes, and the transfer structs.
// No dependencies.
package qrk_pkg;

  // Ring depth must stay a power of two so that index wrap is plain truncation.
  localparam int QUEUE_DEPTH = 256;
  localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = 9;
  localparam int DATA_W      = 32;

  // Operation codes
  localparam logic [1:0] OP_ENQ = 2'd0;
  localparam logic [1:0] OP_DEQ = 2'd1;
  localparam logic [1:0] OP_REV = 2'd2;
  localparam logic [1:0] OP_NOP = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_INVALID = 2'd3;

  typedef struct packed {
    logic [1:0]              op;
    logic signed [DATA_W-1:0] value;
    logic [CNT_W-1:0]        reverse_count;
  } cmd_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] data_out;
    logic [1:0]              status;
    logic [CNT_W-1:0]        occupancy;
  } result_t;

endpackage

// File: rtl/core/queue_with_reverse_first_k.sv
// Top level of the queue with reverse-first-k block: ring store, pointers, sequencer.
// Depends on qrk_pkg.
//
// Usage:
//   A command (op, value, reverse_count) transfers on a rising edge where start is
//   high and busy is low. Exactly one result (data_out, status, occupancy) follows,
//   shown for one cycle with done high; the receiver always takes it.
//   Sequencing and throughput:
//     enqueue, no-op and any rejected command: result registered in the cycle after
//       the transfer, and busy stays low, so one command per cycle.
//     dequeue: one registered read of the single store port, then the result.
//     reverse of k entries (k clamped to occupancy): floor(k/2) swaps of end pairs;
//       each swap uses the one store port for two reads and two writes.
//   The next command may transfer in the same cycle a result is shown.
//   Reset (rst, synchronous) empties the queue: head, tail and count go to zero.
//   Store contents are not cleared; only occupied entries are ever read.
module queue_with_reverse_first_k (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  qrk_pkg::cmd_t    cmd,
  output logic             busy,
  output logic             done,
  output qrk_pkg::result_t result
);
  import qrk_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEQ  = 3'd1;
  localparam logic [2:0] S_RD_A = 3'd2;
  localparam logic [2:0] S_RD_B = 3'd3;
  localparam logic [2:0] S_WR_A = 3'd4;
  localparam logic [2:0] S_WR_B = 3'd5;

  logic [2:0]        state;
  logic [ADDR_W-1:0] head;
  logic [ADDR_W-1:0] tail;
  logic [CNT_W-1:0]  count;
  logic [ADDR_W-1:0] lo;
  logic [ADDR_W-1:0] hi;
  logic [DATA_W-1:0] hold_a;
  logic [DATA_W-1:0] rd_data;

  logic [DATA_W-1:0] mem [QUEUE_DEPTH];

  logic              accept;
  logic              full;
  logic [CNT_W-1:0]  k_lim;
  logic [CNT_W-1:0]  k_lim_m1;
  logic [ADDR_W-1:0] lo_next;
  logic [ADDR_W-1:0] hi_next;
  logic [ADDR_W-1:0] addr_a;
  logic [ADDR_W-1:0] addr_b;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic [DATA_W-1:0] wr_data;
  logic              wr_en;

  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign full     = (count == CNT_W'(QUEUE_DEPTH));
  assign k_lim    = (cmd.reverse_count > count) ? count : cmd.reverse_count;
  assign k_lim_m1 = k_lim - CNT_W'(1);
  assign lo_next  = lo + ADDR_W'(1);
  assign hi_next  = hi - ADDR_W'(1);
  assign addr_a   = head + lo;
  assign addr_b   = head + hi;

  // Steer the single store port
  always_comb begin
    rd_addr = head;
    wr_en   = 1'b0;
    wr_addr = tail;
    wr_data = cmd.value;
    unique case (state)
      S_IDLE: begin
        wr_en = accept && (cmd.op == OP_ENQ) && !full;
      end
      S_RD_A: rd_addr = addr_a;
      S_RD_B: rd_addr = addr_b;
      S_WR_A: begin
        wr_en   = 1'b1;
        wr_addr = addr_a;
        wr_data = rd_data;
      end
      S_WR_B: begin
        wr_en   = 1'b1;
        wr_addr = addr_b;
        wr_data = hold_a;
      end
      default: ;
    endcase
  end

  // Ring store with registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // Sequence commands and post results
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      tail  <= '0;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            result.data_out  <= '0;
            result.status    <= ST_OK;
            result.occupancy <= count;
            unique case (cmd.op)
              OP_ENQ: begin
                done <= 1'b1;
                if (full) begin
                  result.status <= ST_FULL;
                end else begin
                  tail             <= tail + ADDR_W'(1);
                  count            <= count + CNT_W'(1);
                  result.occupancy <= count + CNT_W'(1);
                end
              end
              OP_DEQ: begin
                if (count == '0) begin
                  done          <= 1'b1;
                  result.status <= ST_EMPTY;
                end else begin
                  state <= S_DEQ;
                end
              end
              OP_REV: begin
                if (count == '0 || cmd.reverse_count == '0) begin
                  done          <= 1'b1;
                  result.status <= ST_INVALID;
                end else if (k_lim == CNT_W'(1)) begin
                  done <= 1'b1;
                end else begin
                  lo    <= '0;
                  hi    <= k_lim_m1[ADDR_W-1:0];
                  state <= S_RD_A;
                end
              end
              OP_NOP: done <= 1'b1;
            endcase
          end
        end
        S_DEQ: begin
          done             <= 1'b1;
          result.data_out  <= rd_data;
          result.status    <= ST_OK;
          result.occupancy <= count - CNT_W'(1);
          head             <= head + ADDR_W'(1);
          count            <= count - CNT_W'(1);
          state            <= S_IDLE;
        end
        S_RD_A: state <= S_RD_B;
        S_RD_B: begin
          // hold the low entry while the high one is read
          hold_a <= rd_data;
          state  <= S_WR_A;
        end
        S_WR_A: state <= S_WR_B;
        S_WR_B: begin
          lo <= lo_next;
          hi <= hi_next;
          if (lo_next < hi_next) begin
            state <= S_RD_A;
          end else begin
            done             <= 1'b1;
            result.data_out  <= '0;
            result.status    <= ST_OK;
            result.occupancy <= count;
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
